FILE: rtl/core/renc_pkg.sv
// Shared types, constants and helpers for the rotary encoder decoder.
// No dependencies; used by every module in rtl/core.
package renc_pkg;

  // Internal width of the position and run counters
  localparam int COUNT_WIDTH = 16;
  // Compare width: room for the counters and the 15-bit limit with sign and carry
  localparam int CALC_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

  localparam int DEBOUNCE_W = 16;
  localparam int MAXCNT_W   = 15;
  localparam int STAMP_W    = 32;
  localparam int OUT_W      = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [MAXCNT_W-1:0]   POS_LIMIT_RST = MAXCNT_W'(20);
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = '0;

  // Register index, taken from paddr[2]
  localparam logic REG_DEBOUNCE  = 1'b0;
  localparam logic REG_POS_LIMIT = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] RUN_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic [COUNT_WIDTH-1:0] RUN_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic [CALC_W-1:0] CNT_MAX_C =
    {{(CALC_W-COUNT_WIDTH+1){1'b0}}, {(COUNT_WIDTH-1){1'b1}}};

  typedef logic signed [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [MAXCNT_W-1:0]   pos_limit;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic               clk_level;
    logic               dt_level;
    logic [STAMP_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic                    turned;
    logic signed [OUT_W-1:0] position;
    logic signed [OUT_W-1:0] clicks_in_direction;
    logic                    clockwise;
  } result_t;

  // Counter to 16-bit output field: sign-extend if narrower, low bits if wider
  function automatic logic signed [OUT_W-1:0] to_out(input count_t v);
    logic signed [CALC_W-1:0] ext;
    ext = CALC_W'(v);
    return ext[OUT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/renc_apb_regs.sv
// APB-style configuration registers: debounce window and position limit.
// Depends on renc_pkg.
module renc_apb_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [renc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [renc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [renc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output renc_pkg::cfg_t                     cfg
);

  logic [renc_pkg::DEBOUNCE_W-1:0] debounce_r, debounce_nxt;
  logic [renc_pkg::MAXCNT_W-1:0]   pos_limit_r, pos_limit_nxt;
  logic                            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    debounce_nxt  = debounce_r;
    pos_limit_nxt = pos_limit_r;
    if (wr_en) begin
      case (paddr[2])
        renc_pkg::REG_DEBOUNCE:  debounce_nxt  = pwdata[renc_pkg::DEBOUNCE_W-1:0];
        renc_pkg::REG_POS_LIMIT: pos_limit_nxt = pwdata[renc_pkg::MAXCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= renc_pkg::DEBOUNCE_RST;
      pos_limit_r <= renc_pkg::POS_LIMIT_RST;
    end else begin
      debounce_r  <= debounce_nxt;
      pos_limit_r <= pos_limit_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      renc_pkg::REG_DEBOUNCE:  prdata = renc_pkg::APB_DATA_W'(debounce_r);
      renc_pkg::REG_POS_LIMIT: prdata = renc_pkg::APB_DATA_W'(pos_limit_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.debounce_ms = debounce_r;
  assign cfg.pos_limit   = pos_limit_r;

endmodule

FILE: rtl/core/renc_step.sv
// Decoder state and the per-item update: edge detect, debounce, counters.
// Depends on renc_pkg.
module renc_step (
  input  logic              clk,
  input  logic              rst_n,
  input  renc_pkg::cfg_t    cfg,
  input  renc_pkg::item_t   item,
  input  logic              fire,
  output renc_pkg::result_t res
);

  logic                         prev_clk_r, prev_clk_nxt;
  logic                         last_cw_r, last_cw_nxt;
  logic [renc_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;
  renc_pkg::count_t             pos_r, pos_nxt;
  renc_pkg::count_t             run_r, run_nxt;

  logic                         falling;
  logic                         cw_raw, cw;
  logic [renc_pkg::STAMP_W-1:0] elapsed;
  logic                         reject;
  logic signed [renc_pkg::CALC_W-1:0] max_w, lim_w, pos_w, step_w;

  always_comb begin
    falling = !item.cmd && prev_clk_r && !item.clk_level;
    cw_raw  = item.dt_level != item.clk_level;
    elapsed = item.now_ms - stamp_r;
    reject  = (cw_raw != last_cw_r) &&
              (elapsed < renc_pkg::STAMP_W'(cfg.debounce_ms));
    cw      = reject ? last_cw_r : cw_raw;

    max_w = signed'(renc_pkg::CALC_W'(cfg.pos_limit));
    lim_w = (max_w > signed'(renc_pkg::CNT_MAX_C)) ? signed'(renc_pkg::CNT_MAX_C) : max_w;
    pos_w = renc_pkg::CALC_W'(pos_r);
    step_w = cw ? (pos_w + renc_pkg::CALC_W'(1)) : (pos_w - renc_pkg::CALC_W'(1));

    prev_clk_nxt = prev_clk_r;
    last_cw_nxt  = last_cw_r;
    stamp_nxt    = stamp_r;
    pos_nxt      = pos_r;
    run_nxt      = run_r;

    if (item.cmd) begin
      pos_nxt     = '0;
      run_nxt     = '0;
      last_cw_nxt = 1'b1;
    end else begin
      prev_clk_nxt = item.clk_level;
      if (falling) begin
        // run restarts at +/-1 on a change of direction, else saturates
        if (last_cw_r && cw) begin
          if (run_r != renc_pkg::RUN_MAX) run_nxt = run_r + renc_pkg::COUNT_WIDTH'(1);
        end else if (last_cw_r) begin
          run_nxt = '1;
        end else if (!cw) begin
          if (run_r != renc_pkg::RUN_MIN) run_nxt = run_r - renc_pkg::COUNT_WIDTH'(1);
        end else begin
          run_nxt = renc_pkg::COUNT_WIDTH'(1);
        end

        if (cw ? (step_w > lim_w) : (step_w < -lim_w)) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = step_w[renc_pkg::COUNT_WIDTH-1:0];
        end
        last_cw_nxt = cw;
        stamp_nxt   = item.now_ms;
      end
    end

    res.turned              = falling;
    res.position            = renc_pkg::to_out(pos_nxt);
    res.clicks_in_direction = renc_pkg::to_out(run_nxt);
    res.clockwise           = last_cw_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_clk_r <= 1'b1;
      last_cw_r  <= 1'b1;
      stamp_r    <= '0;
      pos_r      <= '0;
      run_r      <= '0;
    end else if (fire) begin
      prev_clk_r <= prev_clk_nxt;
      last_cw_r  <= last_cw_nxt;
      stamp_r    <= stamp_nxt;
      pos_r      <= pos_nxt;
      run_r      <= run_nxt;
    end
  end

endmodule

FILE: rtl/core/rotary_encoder_decoder_core.sv
// Top level of the rotary encoder decoder: input register, update stage, result register.
// Depends on renc_pkg, renc_apb_regs and renc_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per sample: cmd selects a
//   pin sample (clock/data levels with a ms timestamp) or a clear of the counts.
//   Result channel (out_valid/out_ready) returns exactly one result per item, in order.
//   The APB-style port writes debounce_ms at 0x0 and the position limit at 0x4;
//   pready is tied high, and registers should only be written while the block is idle.
// Timing:
//   An item is taken into the input register, goes through the combinational update
//   logic against the decoder state, and lands in the result register: out_valid
//   rises when the result register is loaded, which a low out_ready can hold back.
//   One item per cycle is sustained while out_ready stays high, limited by the single
//   update stage whose state feeds the next item.
// Reset (rst_n low, synchronous): both stages empty, counts zero, clockwise set,
//   previous clock level high, debounce 0, position limit 20.
// Stall: while out_ready is low the result holds; one more item waits in the
//   input register, then in_ready drops.
module rotary_encoder_decoder_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic                                 in_clk_level,
  input  logic                                 in_dt_level,
  input  logic [renc_pkg::STAMP_W-1:0]         in_now_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_turned,
  output logic signed [renc_pkg::OUT_W-1:0]    out_position,
  output logic signed [renc_pkg::OUT_W-1:0]    out_clicks_in_direction,
  output logic                                 out_clockwise,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [renc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [renc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [renc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  renc_pkg::cfg_t    cfg;
  renc_pkg::item_t   item_r;
  renc_pkg::result_t step_res;
  renc_pkg::result_t res_r;

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, s1_fire, in_fire;

  renc_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  renc_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item_r),
    .fire  (s1_fire),
    .res   (step_res)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.cmd       <= in_cmd;
      item_r.clk_level <= in_clk_level;
      item_r.dt_level  <= in_dt_level;
      item_r.now_ms    <= in_now_ms;
    end
    if (s1_fire) begin
      res_r <= step_res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_turned              = res_r.turned;
  assign out_position            = res_r.position;
  assign out_clicks_in_direction = res_r.clicks_in_direction;
  assign out_clockwise           = res_r.clockwise;

endmodule

FILE: rtl/core/renc_checker.sv
// Port-level checks for the rotary encoder decoder, bound to the top level.
// Depends on renc_pkg and rotary_encoder_decoder_core.
module renc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_turned,
  input logic signed [renc_pkg::OUT_W-1:0] out_position,
  input logic signed [renc_pkg::OUT_W-1:0] out_clicks_in_direction,
  input logic                              out_clockwise,
  input logic                              pready
);

  // A stalled result keeps its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) &&
    $stable(out_clicks_in_direction) && $stable(out_turned))
    else $error("result changed while stalled");

  // No click since reset or clear: position is zero and direction clockwise
  a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clicks_in_direction == '0 |-> out_position == '0 && out_clockwise)
    else $error("zero run with non-zero position or anticlockwise");

  // After a click the run is non-zero and its sign follows the direction
  a_run_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_turned |-> out_clicks_in_direction != '0 &&
    out_clockwise == !out_clicks_in_direction[renc_pkg::OUT_W-1])
    else $error("run count disagrees with direction");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind rotary_encoder_decoder_core renc_checker u_renc_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_turned              (out_turned),
  .out_position            (out_position),
  .out_clicks_in_direction (out_clicks_in_direction),
  .out_clockwise           (out_clockwise),
  .pready                  (pready)
);

FILE: tb/rotary_encoder_decoder_core_tb.sv
`timescale 1ns / 100ps
// Testbench for rotary_encoder_decoder_core: directed and random encoder samples,
// each result checked against a decoder model kept in the bench.
// Depends on renc_pkg and the core RTL.
module rotary_encoder_decoder_core_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam logic [renc_pkg::APB_ADDR_W-1:0] ADDR_DEBOUNCE  = {renc_pkg::REG_DEBOUNCE, 2'b00};
  localparam logic [renc_pkg::APB_ADDR_W-1:0] ADDR_POS_LIMIT = {renc_pkg::REG_POS_LIMIT, 2'b00};

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic                                in_cmd;
  logic                                in_clk_level;
  logic                                in_dt_level;
  logic [renc_pkg::STAMP_W-1:0]        in_now_ms;
  logic                                out_valid;
  logic                                out_ready;
  logic                                out_turned;
  logic signed [renc_pkg::OUT_W-1:0]   out_position;
  logic signed [renc_pkg::OUT_W-1:0]   out_clicks_in_direction;
  logic                                out_clockwise;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [renc_pkg::APB_ADDR_W-1:0]     paddr;
  logic [renc_pkg::APB_DATA_W-1:0]     pwdata;
  logic [renc_pkg::APB_DATA_W-1:0]     prdata;
  logic                                pready;

  rotary_encoder_decoder_core DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_cmd                  (in_cmd),
    .in_clk_level            (in_clk_level),
    .in_dt_level             (in_dt_level),
    .in_now_ms               (in_now_ms),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_turned              (out_turned),
    .out_position            (out_position),
    .out_clicks_in_direction (out_clicks_in_direction),
    .out_clockwise           (out_clockwise),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder model state and its copy of the registers
  logic                            mdl_prev_clk;
  logic                            mdl_last_cw;
  logic [renc_pkg::STAMP_W-1:0]    mdl_stamp;
  longint                          mdl_pos;
  longint                          mdl_run;
  logic [renc_pkg::DEBOUNCE_W-1:0] mdl_debounce;
  logic [renc_pkg::MAXCNT_W-1:0]   mdl_pos_limit;

  renc_pkg::item_t   pending_samples[$];
  renc_pkg::result_t expected_readings[$];
  renc_pkg::item_t   cur_sample;
  renc_pkg::result_t want;
  logic              sample_taken;
  int                samples_queued;
  int                samples_taken;
  int                mismatches;
  int                quiet_cycles;
  int                send_idle_pct;
  int                recv_stall_pct;

  // Stimulus generator state
  logic [renc_pkg::STAMP_W-1:0] stamp;
  logic                         turn_cw;

  function automatic renc_pkg::result_t decode_sample(input renc_pkg::item_t s);
    renc_pkg::result_t            r;
    logic                         cw;
    longint                       lim;
    longint                       run_hi;
    longint                       run_lo;
    logic [renc_pkg::STAMP_W-1:0] elapsed;
    run_hi = (longint'(1) <<< (renc_pkg::COUNT_WIDTH - 1)) - 1;
    run_lo = -(longint'(1) <<< (renc_pkg::COUNT_WIDTH - 1));
    r.turned = 1'b0;
    if (s.cmd) begin
      mdl_pos = 0;
      mdl_run = 0;
      mdl_last_cw = 1'b1;
    end else begin
      if (s.clk_level != mdl_prev_clk && !s.clk_level) begin
        cw = (s.dt_level != s.clk_level);
        lim = (longint'(mdl_pos_limit) > run_hi) ? run_hi : longint'(mdl_pos_limit);
        elapsed = s.now_ms - mdl_stamp;
        // reversal inside the debounce window keeps the old direction
        if (cw != mdl_last_cw && elapsed < renc_pkg::STAMP_W'(mdl_debounce))
          cw = mdl_last_cw;
        if (mdl_last_cw && cw) begin
          if (mdl_run < run_hi)
            mdl_run++;
        end else if (mdl_last_cw) begin
          mdl_run = -1;
        end else if (!cw) begin
          if (mdl_run > run_lo)
            mdl_run--;
        end else begin
          mdl_run = 1;
        end
        if (cw) begin
          mdl_pos++;
          if (mdl_pos > lim)
            mdl_pos = 0;
        end else begin
          mdl_pos--;
          if (mdl_pos < -lim)
            mdl_pos = 0;
        end
        mdl_last_cw = cw;
        mdl_stamp = s.now_ms;
        r.turned = 1'b1;
      end
      mdl_prev_clk = s.clk_level;
    end
    r.position = mdl_pos[renc_pkg::OUT_W-1:0];
    r.clicks_in_direction = mdl_run[renc_pkg::OUT_W-1:0];
    r.clockwise = mdl_last_cw;
    return r;
  endfunction

  function automatic void queue_sample(input logic cmd, input logic clk_l, input logic dt_l,
                                       input logic [renc_pkg::STAMP_W-1:0] now);
    renc_pkg::item_t s;
    s.cmd = cmd;
    s.clk_level = clk_l;
    s.dt_level = dt_l;
    s.now_ms = now;
    pending_samples.push_back(s);
    samples_queued++;
  endfunction

  // Mostly well-formed clicks with gaps around the debounce window, plus clears and noise
  task automatic queue_random_samples(input int count);
    int                           k;
    int                           pick;
    logic [renc_pkg::STAMP_W-1:0] gap;
    k = 0;
    while (k < count) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        queue_sample(1'b1, 1'($urandom), 1'($urandom), $urandom);
        k++;
      end else if (pick < 14) begin
        queue_sample(1'b0, 1'($urandom), 1'($urandom),
                     $urandom_range(1) ? $urandom : stamp + $urandom_range(3));
        k++;
      end else begin
        if ($urandom_range(99) < 30)
          turn_cw = !turn_cw;
        case ($urandom_range(5))
          0:       gap = '0;
          1:       gap = $urandom_range(3);
          2:       gap = renc_pkg::STAMP_W'(mdl_debounce) - 1;
          3:       gap = renc_pkg::STAMP_W'(mdl_debounce);
          4:       gap = renc_pkg::STAMP_W'(mdl_debounce) + 1;
          default: gap = $urandom;
        endcase
        queue_sample(1'b0, 1'b1, 1'($urandom), stamp + (gap >> 1));
        stamp = stamp + gap;
        queue_sample(1'b0, 1'b0, turn_cw, stamp);
        k += 2;
      end
    end
  endtask

  // Run of clicks in one direction
  task automatic queue_long_run(input logic cw, input int clicks);
    int i;
    for (i = 0; i < clicks; i++) begin
      queue_sample(1'b0, 1'b1, 1'($urandom), stamp);
      stamp++;
      queue_sample(1'b0, 1'b0, cw, stamp);
    end
  endtask

  task automatic write_reg(input logic [renc_pkg::APB_ADDR_W-1:0] addr,
                           input logic [renc_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random; only the register's own width is kept
  task automatic set_config(input logic [renc_pkg::DEBOUNCE_W-1:0] deb,
                            input logic [renc_pkg::MAXCNT_W-1:0] maxc);
    write_reg(ADDR_DEBOUNCE, {16'($urandom), deb});
    write_reg(ADDR_POS_LIMIT, {17'($urandom), maxc});
    mdl_debounce = deb;
    mdl_pos_limit = maxc;
  endtask

  task automatic wait_idle();
    while (samples_taken != samples_queued || expected_readings.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic start_phase(input logic [renc_pkg::DEBOUNCE_W-1:0] deb,
                             input logic [renc_pkg::MAXCNT_W-1:0] maxc,
                             input int send_pct, input int stall_pct);
    wait_idle();
    set_config(deb, maxc);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Input driver: holds an item until it is taken
  always @(negedge clk) begin
    if (!in_valid || sample_taken) begin
      if (rst_n && pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_sample = pending_samples.pop_front();
        in_cmd <= cur_sample.cmd;
        in_clk_level <= cur_sample.clk_level;
        in_dt_level <= cur_sample.dt_level;
        in_now_ms <= cur_sample.now_ms;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    sample_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_readings.push_back(decode_sample(cur_sample));
      samples_taken++;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (out_turned !== want.turned) begin
          $error("turned: expected %0d, got %0d", want.turned, out_turned);
          mismatches++;
        end
        if (out_position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_position);
          mismatches++;
        end
        if (out_clicks_in_direction !== want.clicks_in_direction) begin
          $error("clicks_in_direction: expected %0d, got %0d",
                 want.clicks_in_direction, out_clicks_in_direction);
          mismatches++;
        end
        if (out_clockwise !== want.clockwise) begin
          $error("clockwise: expected %0d, got %0d", want.clockwise, out_clockwise);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_clk_level = 1'b1;
    in_dt_level = 1'b0;
    in_now_ms = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_taken = 1'b0;
    samples_queued = 0;
    samples_taken = 0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mdl_prev_clk = 1'b1;
    mdl_last_cw = 1'b1;
    mdl_stamp = '0;
    mdl_pos = 0;
    mdl_run = 0;
    mdl_debounce = renc_pkg::DEBOUNCE_RST;
    mdl_pos_limit = renc_pkg::POS_LIMIT_RST;
    stamp = '0;
    turn_cw = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first fall from the idle-high line, clears, no-edge samples
    queue_sample(1'b0, 1'b0, 1'b0, 32'h0000_0000);
    queue_sample(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
    queue_sample(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
    queue_sample(1'b0, 1'b0, 1'b1, 32'h0000_0001);
    queue_sample(1'b0, 1'b1, 1'b0, 32'h0000_0002);
    queue_sample(1'b0, 1'b0, 1'b1, 32'h0000_0003);
    queue_sample(1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
    queue_sample(1'b0, 1'b0, 1'b0, 32'h0000_0004);
    queue_sample(1'b0, 1'b1, 1'b0, 32'h0000_0005);
    queue_sample(1'b1, 1'b1, 1'b1, 32'h0000_0000);
    queue_sample(1'b0, 1'b0, 1'b0, 32'h0000_0006);
    queue_sample(1'b0, 1'b1, 1'b1, 32'h0000_0007);
    queue_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    queue_random_samples(120);

    // Short window: reversal just inside, at the edge, and across the stamp wrap
    start_phase(16'd5, 15'd3, 52, 0);
    queue_sample(1'b1, 1'b0, 1'b0, 32'h0000_0000);
    queue_sample(1'b0, 1'b1, 1'b0, 32'd99);
    queue_sample(1'b0, 1'b0, 1'b1, 32'd100);
    queue_sample(1'b0, 1'b1, 1'b1, 32'd101);
    queue_sample(1'b0, 1'b0, 1'b0, 32'd104);
    queue_sample(1'b0, 1'b1, 1'b0, 32'd105);
    queue_sample(1'b0, 1'b0, 1'b0, 32'd109);
    queue_sample(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFD);
    queue_sample(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFE);
    queue_sample(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
    queue_sample(1'b0, 1'b0, 1'b0, 32'h0000_0002);
    stamp = 32'h0000_0002;
    queue_random_samples(150);

    start_phase(16'hFFFF, 15'h7FFF, 0, 52);
    queue_random_samples(150);

    // Zero limit: once the position is zero, every click leaves it at zero
    start_phase(16'd0, 15'd0, 14, 14);
    queue_random_samples(120);

    start_phase(16'd100, 15'd1, 0, 0);
    queue_random_samples(120);

    start_phase(16'd20, 15'd20, 0, 52);
    queue_random_samples(100);

    // Steady runs both ways with no debounce and the widest limit
    start_phase(16'd0, 15'h7FFF, 0, 0);
    queue_sample(1'b1, 1'b1, 1'b0, stamp);
    queue_long_run(1'b1, 12);
    queue_long_run(1'b0, 12);

    start_phase(16'd1, 15'd2, 14, 14);
    queue_random_samples(120);

    wait_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/renc_pkg.sv
rtl/core/renc_apb_regs.sv
rtl/core/renc_step.sv
rtl/core/rotary_encoder_decoder_core.sv
rtl/core/renc_checker.sv
tb/rotary_encoder_decoder_core_tb.sv
